// ===== sv/ghe_pkg.sv =====
// Shared types and constants for the geohash point encoder.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ghe_pkg;

  localparam int MAX_CHARS_DEF       = 63;
  localparam int COORD_FRAC_BITS_DEF = 23;

  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int COUNT_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int CODE_W   = 5;
  localparam int BOUND_W  = 64;
  localparam int BOUND_FRAC_BITS = 55;

  // Bounds are offset binary (value + 2^63) in units of 2^-55 degree.
  localparam logic [BOUND_W-1:0] SIGN_BIAS = 64'h8000_0000_0000_0000;
  localparam logic [BOUND_W-1:0] LAT_LO_INIT = SIGN_BIAS - (64'd90 << BOUND_FRAC_BITS);
  localparam logic [BOUND_W-1:0] LAT_HI_INIT = SIGN_BIAS + (64'd90 << BOUND_FRAC_BITS);
  localparam logic [BOUND_W-1:0] LON_LO_INIT = SIGN_BIAS - (64'd180 << BOUND_FRAC_BITS);
  localparam logic [BOUND_W-1:0] LON_HI_INIT = SIGN_BIAS + (64'd180 << BOUND_FRAC_BITS);

  // Base32 geohash alphabet: 0-9 b-z without a, i, l, o.
  localparam logic [CHAR_W-1:0] GH_ALPHABET [0:31] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
  };

  // One point waiting for the bisection engine, count already clamped.
  typedef struct packed {
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic [COUNT_W-1:0]      char_count;
  } job_t;

endpackage

// ===== sv/ghe_stream_if.sv =====
// Valid/ready channels of the geohash point encoder: point requests in,
// characters out. Depends on ghe_pkg for field widths.
`timescale 1ns / 1ps

interface ghe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ghe_pkg::LAT_W-1:0]     latitude;
  logic signed [ghe_pkg::LON_W-1:0]     longitude;
  logic [ghe_pkg::COUNT_W-1:0]          char_count;

  modport source (output valid, latitude, longitude, char_count, input ready);
  modport sink   (input valid, latitude, longitude, char_count, output ready);
endinterface

interface ghe_out_if;
  logic                          valid;
  logic                          ready;
  logic [ghe_pkg::CHAR_W-1:0]    hash_char;
  logic                          last_char;

  modport source (output valid, hash_char, last_char, input ready);
  modport sink   (input valid, hash_char, last_char, output ready);
endinterface

// ===== sv/ghe_front.sv =====
// Front end: accepts point requests, clamps the character count and
// holds them in a two-entry queue for the engine. Uses ghe_pkg, ghe_in_if.
`timescale 1ns / 1ps

module ghe_front #(
  parameter int MAX_CHARS = ghe_pkg::MAX_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ghe_in_if.sink         in_stream,
  output logic           job_valid,
  output ghe_pkg::job_t  job,
  input  logic           job_pop
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  ghe_pkg::job_t         queue_r [QDEPTH];
  logic [PTR_W-1:0]      wr_ptr_r;
  logic [PTR_W-1:0]      rd_ptr_r;
  logic [FILL_W-1:0]     fill_r;
  ghe_pkg::job_t         job_nxt;
  logic                  push;
  logic                  pop;

  // Clamp the count into 1..MAX_CHARS.
  always_comb begin
    job_nxt.latitude   = in_stream.latitude;
    job_nxt.longitude  = in_stream.longitude;
    job_nxt.char_count = in_stream.char_count;
    priority if (in_stream.char_count == '0) begin
      job_nxt.char_count = ghe_pkg::COUNT_W'(1);
    end else if (in_stream.char_count > ghe_pkg::COUNT_W'(MAX_CHARS)) begin
      job_nxt.char_count = ghe_pkg::COUNT_W'(MAX_CHARS);
    end
  end

  assign in_stream.ready = (fill_r != FILL_W'(QDEPTH));
  assign push      = in_stream.valid && in_stream.ready;
  assign job_valid = (fill_r != '0);
  assign pop       = job_pop && job_valid;
  assign job       = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

endmodule

// ===== sv/ghe_engine.sv =====
// Back end: bisects longitude and latitude one bit per cycle unless a full
// output register stalls it, packs five bits into a character and holds it
// in an output register. Uses ghe_pkg and ghe_out_if.
`timescale 1ns / 1ps

module ghe_engine #(
  parameter int MAX_CHARS       = ghe_pkg::MAX_CHARS_DEF,
  parameter int COORD_FRAC_BITS = ghe_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  ghe_pkg::job_t  job,
  output logic           job_pop,
  ghe_out_if.source      out_stream
);

  localparam int CNT_W   = $clog2(MAX_CHARS + 1);
  localparam int SHIFT   = ghe_pkg::BOUND_FRAC_BITS - COORD_FRAC_BITS;
  localparam int THR_W   = ghe_pkg::BOUND_W - SHIFT;
  localparam int BW      = ghe_pkg::BOUND_W;
  localparam int PHASE_W = $clog2(ghe_pkg::CODE_W);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                         state_r;
  logic signed [ghe_pkg::LAT_W-1:0] lat_r;
  logic signed [ghe_pkg::LON_W-1:0] lon_r;
  logic [CNT_W-1:0]               left_r;
  logic [PHASE_W-1:0]             phase_r;
  logic [ghe_pkg::CODE_W-2:0]     code_r;
  logic                           lon_turn_r;
  logic [BW-1:0]                  lat_lo_r, lat_hi_r, lon_lo_r, lon_hi_r;
  logic                           out_valid_r;
  logic [ghe_pkg::CHAR_W-1:0]     char_r;
  logic                           last_r;

  logic [BW-1:0]                  lo_sel, hi_sel, mid;
  logic [BW:0]                    sum;
  logic [THR_W-1:0]               top;
  logic signed [THR_W-1:0]        thr;
  logic signed [ghe_pkg::LON_W-1:0] thr_ext, coord_sel;
  logic                           bit_v;
  logic [ghe_pkg::CODE_W-1:0]     code_nxt;
  logic                           char_step, slot_free, advance;

  always_comb begin
    lo_sel    = lon_turn_r ? lon_lo_r : lat_lo_r;
    hi_sel    = lon_turn_r ? lon_hi_r : lat_hi_r;
    sum       = {1'b0, lo_sel} + {1'b0, hi_sel};
    mid       = sum[BW:1];
    // Threshold in coordinate units: top bits of the midpoint, bias removed.
    top       = mid[BW-1:SHIFT];
    thr       = {~top[THR_W-1], top[THR_W-2:0]};
    thr_ext   = ghe_pkg::LON_W'(thr);
    coord_sel = lon_turn_r ? lon_r : ghe_pkg::LON_W'(lat_r);
    bit_v     = (coord_sel > thr_ext);
    code_nxt  = {code_r, bit_v};
  end

  assign char_step = (phase_r == PHASE_W'(ghe_pkg::CODE_W - 1));
  assign slot_free = !out_valid_r || out_stream.ready;
  assign advance   = (state_r == ST_RUN) && (!char_step || slot_free);
  assign job_pop   = (state_r == ST_IDLE) && job_valid;

  assign out_stream.valid     = out_valid_r;
  assign out_stream.hash_char = char_r;
  assign out_stream.last_char = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the held character once taken, unless a new one replaces it.
      if (out_valid_r && out_stream.ready && !(advance && char_step)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            lat_r      <= job.latitude;
            lon_r      <= job.longitude;
            left_r     <= job.char_count[CNT_W-1:0];
            phase_r    <= '0;
            code_r     <= '0;
            lon_turn_r <= 1'b1;
            lat_lo_r   <= ghe_pkg::LAT_LO_INIT;
            lat_hi_r   <= ghe_pkg::LAT_HI_INIT;
            lon_lo_r   <= ghe_pkg::LON_LO_INIT;
            lon_hi_r   <= ghe_pkg::LON_HI_INIT;
            state_r    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance) begin
            // Raise the lower bound on a one, lower the upper bound on a zero.
            if (lon_turn_r) begin
              if (bit_v) lon_lo_r <= mid;
              else       lon_hi_r <= mid;
            end else begin
              if (bit_v) lat_lo_r <= mid;
              else       lat_hi_r <= mid;
            end
            lon_turn_r <= !lon_turn_r;
            if (char_step) begin
              out_valid_r <= 1'b1;
              char_r      <= ghe_pkg::GH_ALPHABET[code_nxt];
              last_r      <= (left_r == CNT_W'(1));
              phase_r     <= '0;
              code_r      <= '0;
              left_r      <= left_r - CNT_W'(1);
              if (left_r == CNT_W'(1)) begin
                state_r <= ST_IDLE;
              end
            end else begin
              phase_r <= phase_r + PHASE_W'(1);
              code_r  <= code_nxt[ghe_pkg::CODE_W-2:0];
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/geohash_point_encoder_top.sv =====
// Geohash point encoder: one bisection bit per cycle in a shared engine,
// five bits per character, up to MAX_CHARS characters per point. A full
// output register stalls the engine. A two-entry request queue sits in front.
// Reset (rst_n low, synchronous) empties the queue and idles the engine.
`timescale 1ns / 1ps

module geohash_point_encoder_top #(
  parameter int MAX_CHARS       = ghe_pkg::MAX_CHARS_DEF,
  parameter int COORD_FRAC_BITS = ghe_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ghe_in_if.sink      in_stream,
  ghe_out_if.source   out_stream
);

  logic           job_valid;
  logic           job_pop;
  ghe_pkg::job_t  job;

  ghe_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  ghe_engine #(
    .MAX_CHARS       (MAX_CHARS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .out_stream (out_stream)
  );

endmodule

// ===== bench/geohash_point_encoder_checker.sv =====
// Scoreboard for the geohash point encoder: watches both channels, predicts
// the characters of every accepted point request and compares them in order.
// Depends on ghe_pkg and the channel interfaces in ghe_stream_if.sv.
`timescale 1ns / 1ps

module geohash_point_encoder_checker (
  input  logic clk,
  input  logic rst_n,
  ghe_in_if    in_mon,
  ghe_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   chars_seen
);

  localparam int COORD_SHIFT = ghe_pkg::BOUND_FRAC_BITS - ghe_pkg::COORD_FRAC_BITS_DEF;

  typedef struct {
    logic [ghe_pkg::CHAR_W-1:0] hash_char;
    logic                       last_char;
  } hash_char_t;

  hash_char_t expected_chars[$];
  int         errors  = 0;
  int         checked = 0;

  assign fail_count = errors;
  assign chars_seen = checked;

  // One bisection step; bounds are offset binary, midpoint floored.
  function automatic logic split_range(inout logic [63:0] lo, inout logic [63:0] hi,
                                       input longint coord);
    logic [63:0] mid;
    longint      thr;
    mid = (lo >> 1) + (hi >> 1) + {63'd0, lo[0] & hi[0]};
    thr = $signed(mid >> COORD_SHIFT) - (longint'(1) << (63 - COORD_SHIFT));
    if (coord > thr) begin
      lo = mid;
      split_range = 1'b1;
    end else begin
      hi = mid;
      split_range = 1'b0;
    end
  endfunction

  function automatic void encode_point(input logic signed [ghe_pkg::LAT_W-1:0] lat,
                                       input logic signed [ghe_pkg::LON_W-1:0] lon,
                                       input logic [ghe_pkg::COUNT_W-1:0] cnt);
    logic [63:0]                 lat_lo, lat_hi, lon_lo, lon_hi;
    logic [ghe_pkg::CODE_W-1:0]  code;
    logic                        lon_turn;
    int                          n;
    hash_char_t                  item;
    lat_lo = ghe_pkg::LAT_LO_INIT;
    lat_hi = ghe_pkg::LAT_HI_INIT;
    lon_lo = ghe_pkg::LON_LO_INIT;
    lon_hi = ghe_pkg::LON_HI_INIT;
    n = (cnt == 0) ? 1 : int'(cnt);
    if (n > ghe_pkg::MAX_CHARS_DEF) n = ghe_pkg::MAX_CHARS_DEF;
    lon_turn = 1'b1;
    for (int k = 0; k < n; k++) begin
      code = '0;
      for (int b = 0; b < ghe_pkg::CODE_W; b++) begin
        if (lon_turn) code = {code[3:0], split_range(lon_lo, lon_hi, longint'(lon))};
        else          code = {code[3:0], split_range(lat_lo, lat_hi, longint'(lat))};
        lon_turn = !lon_turn;
      end
      item.hash_char = ghe_pkg::GH_ALPHABET[code];
      item.last_char = (k == n - 1);
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    hash_char_t want;
    if (rst_n) begin
      // Compare before taking a new request so a stray character is never
      // matched against a point accepted on the same edge.
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_chars.size() == 0) begin
          errors++;
          $error("unexpected character: hash_char %0h last_char %0b",
                 out_mon.hash_char, out_mon.last_char);
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.hash_char !== want.hash_char) begin
            errors++;
            $error("hash_char: expected %0h actual %0h", want.hash_char, out_mon.hash_char);
          end
          if (out_mon.last_char !== want.last_char) begin
            errors++;
            $error("last_char: expected %0b actual %0b", want.last_char, out_mon.last_char);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        encode_point(in_mon.latitude, in_mon.longitude, in_mon.char_count);
    end
    pending <= expected_chars.size();
  end

endmodule

// ===== bench/geohash_point_encoder_top_tb.sv =====
// Top of the geohash point encoder bench: clock, reset, point requests and
// receiver stalls; the checker beside the block does all comparison.
// Depends on ghe_pkg, ghe_stream_if.sv and geohash_point_encoder_checker.
`timescale 1ns / 1ps

module geohash_point_encoder_top_tb;

  localparam int LAT90            = 754974720;
  localparam int LON180           = 1509949440;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int CYCLE_LIMIT      = 800000;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic recv_ready = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int points_sent   = 0;
  int cycle_count   = 0;
  int fail_count;
  int pending;
  int chars_seen;

  ghe_in_if  in_ch ();
  ghe_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  geohash_point_encoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  geohash_point_encoder_checker hash_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .chars_seen (chars_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    recv_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_point(input logic [ghe_pkg::LAT_W-1:0] lat,
                            input logic [ghe_pkg::LON_W-1:0] lon,
                            input logic [ghe_pkg::COUNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.latitude   <= lat;
    in_ch.longitude  <= lon;
    in_ch.char_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    points_sent++;
  endtask

  // Hold off new requests until every predicted character has come back.
  task automatic drain_results;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A value on or next to a bisection midpoint at a random depth.
  function automatic longint near_split(input longint half_span, input int max_depth);
    int     j;
    longint m;
    j = $urandom_range(max_depth, 1);
    m = longint'($urandom_range(2 ** (j + 1))) - (longint'(1) << j);
    return m * (half_span >>> j) + longint'($urandom_range(2)) - 1;
  endfunction

  function automatic longint boundary_value(input longint span, input int width);
    case ($urandom_range(4))
      0:       return span;
      1:       return -span;
      2:       return 0;
      3:       return (longint'(1) << (width - 1)) - 1;
      default: return -(longint'(1) << (width - 1));
    endcase
  endfunction

  task automatic send_random_point;
    logic [ghe_pkg::LAT_W-1:0]   lat;
    logic [ghe_pkg::LON_W-1:0]   lon;
    logic [ghe_pkg::COUNT_W-1:0] cnt;
    int                          pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      lat = ghe_pkg::LAT_W'($urandom_range(2 * LAT90) - LAT90);
      lon = $urandom_range(32'd3019898880) - 32'd1509949440;
    end else if (pick < 75) begin
      lat = ghe_pkg::LAT_W'($urandom);
      lon = $urandom;
    end else if (pick < 90) begin
      lat = ghe_pkg::LAT_W'(near_split(longint'(LAT90), 24));
      lon = ghe_pkg::LON_W'(near_split(longint'(LON180), 24));
    end else begin
      lat = ghe_pkg::LAT_W'(boundary_value(longint'(LAT90), ghe_pkg::LAT_W));
      lon = ghe_pkg::LON_W'(boundary_value(longint'(LON180), ghe_pkg::LON_W));
    end
    // Mostly short hashes; long ones keep the engine busy.
    pick = $urandom_range(99);
    if (pick < 70)      cnt = ghe_pkg::COUNT_W'($urandom_range(12, 1));
    else if (pick < 90) cnt = ghe_pkg::COUNT_W'($urandom_range(40, 13));
    else if (pick < 95) cnt = ghe_pkg::COUNT_W'($urandom_range(62, 41));
    else                cnt = $urandom_range(1) ? 6'd63 : 6'd0;
    send_point(lat, lon, cnt);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.latitude   = '0;
    in_ch.longitude  = '0;
    in_ch.char_count = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 78;

    // Origin: every first split lands exactly on the midpoint.
    send_point(31'd0, 32'd0, 6'd12);
    send_point(ghe_pkg::LAT_W'(LAT90), ghe_pkg::LON_W'(LON180), 6'd12);
    send_point(ghe_pkg::LAT_W'(-LAT90), ghe_pkg::LON_W'(-LON180), 6'd12);
    // Far beyond the ranges: all ones, all zeros.
    send_point(31'h3FFF_FFFF, 32'h7FFF_FFFF, 6'd63);
    send_point(31'h4000_0000, 32'h8000_0000, 6'd63);
    send_point(31'h3FFF_FFFF, 32'h8000_0000, 6'd20);
    send_point(31'h4000_0000, 32'h7FFF_FFFF, 6'd20);
    // Zero count gives one character.
    send_point(ghe_pkg::LAT_W'($urandom), $urandom, 6'd0);
    send_point(ghe_pkg::LAT_W'($urandom_range(2 * LAT90) - LAT90), 32'd123456789, 6'd1);
    send_point(31'd377487360, 32'd754974720, 6'd8);
    send_point(-31'd377487360, -32'd754974720, 6'd8);
    send_point(-31'd1, -32'd1, 6'd10);
    send_point(31'd1, 32'd1, 6'd10);
    send_point(31'h2AAA_AAAA, 32'h5555_5555, 6'h2A);
    send_point(31'h5555_5555, 32'hAAAA_AAAA, 6'h15);
    send_point(31'd483580764, 32'd87304306, 6'd11);
    send_point(ghe_pkg::LAT_W'(LAT90 - 1), ghe_pkg::LON_W'(LON180 - 1), 6'd63);
    send_point(ghe_pkg::LAT_W'(-LAT90 + 1), ghe_pkg::LON_W'(-LON180 + 1), 6'd7);
    send_point(ghe_pkg::LAT_W'(near_split(longint'(LAT90), 24)),
               ghe_pkg::LON_W'(near_split(longint'(LON180), 24)), 6'd40);
    send_point(31'd0, 32'd0, 6'd63);
    drain_results;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 14; recv_idle_pct = 78; end
        1:       begin send_idle_pct = 78; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ($urandom_range(49) == 0) drain_results;
        send_random_point;
      end
      drain_results;
    end

    repeat (40) @(posedge clk);
    $display("Encoded %0d points into %0d checked characters: counts 0..63, in-range,",
             points_sent, chars_seen);
    $display("out-of-range and split-point coordinates under three stall mixes.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ghe_pkg.sv
sv/ghe_stream_if.sv
sv/ghe_front.sv
sv/ghe_engine.sv
sv/geohash_point_encoder_top.sv
bench/geohash_point_encoder_checker.sv
bench/geohash_point_encoder_top_tb.sv
